### src/gqls_pkg.sv
// shared constants, codes and types of the grid q-learning step block
package gqls_pkg;

	localparam int ROWS   = 16;
	localparam int COLS   = 16;
	localparam int NACT   = 4;
	localparam int CELLS  = ROWS * COLS;
	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLS);
	localparam int CELL_W = $clog2(CELLS);
	localparam int QW     = 32;
	localparam int EPS_W  = 10;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 56;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [EPS_W-1:0] EPS_FULL = EPS_W'(1000);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [1:0] ACT_UP    = 2'd0;
	localparam logic [1:0] ACT_RIGHT = 2'd1;
	localparam logic [1:0] ACT_DOWN  = 2'd2;
	localparam logic [1:0] ACT_LEFT  = 2'd3;

	localparam logic [2:0] TILE_EMPTY  = 3'd0;
	localparam logic [2:0] TILE_BOMB   = 3'd1;
	localparam logic [2:0] TILE_CHARGE = 3'd2;
	localparam logic [2:0] TILE_START  = 3'd3;
	localparam logic [2:0] TILE_GOAL   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOMB_REWARD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_REWARD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_REWARD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_END_REWARD    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_DECAY = 3'd6;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHOOSE,
		ST_READ,
		ST_FUT,
		ST_TGT,
		ST_MUL,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic start;
		logic choose;
		logic sel_nxt;
		logic fut;
		logic tgt;
		logic mul;
		logic wr;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_busy;
	} dp_stat_t;

endpackage

### src/grid_q_learning_step_top.sv
// top level of the grid q-learning step block
// tabular q-learning agent on a 16 x 16 grid with an epsilon-greedy policy
// input stream s_*: s_tuser selects the item, 0 loads one tile, 1 takes one step
// a load gives no result; a step gives one result on m_*
// a step occupies the block, which takes no new item meanwhile, through the read
// of the current cell, the read of the entered cell and the two dependent
// multiplies followed by the write back of the q row
// config channel cfg_*: always ready, one register write per transfer,
// to be used only while no step is in flight
// after reset the q table and tile map are cleared one cell per cycle,
// all 256 cells, during which s_tready stays low; config writes are still taken
// results sit in an output register: the next item is accepted while a
// result waits, and a step stalls at its write back while the receiver
// holds m_tready low with an earlier result still pending
// m_tlast marks the step that ended an episode, m_tuser marks an explored move
module grid_q_learning_step_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tile_index[7:0], tile_type[10:8], random_percent[17:11], random_action[19:18]
	input  logic [gqls_pkg::IN_DATA_W-1:0]      s_tdata,
	// operation
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// action_taken[1:0], new_row[5:2], new_col[9:6], reward_given[17:10],
	// updated_value[49:18]
	output logic [gqls_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tlast,
	// explored
	output logic                                m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gqls_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gqls_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import gqls_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	gqls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	gqls_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

### src/gqls_ctrl.sv
// controller state machine of the grid q-learning step block
module gqls_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               s_tuser,
	input  gqls_pkg::dp_stat_t stat,
	output gqls_pkg::dp_cmd_t  cmd
);
	import gqls_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == OP_STEP) begin
						cmd.start = 1'b1;
						state_d   = ST_CHOOSE;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_CHOOSE: begin
				cmd.choose = 1'b1;
				state_d    = ST_READ;
			end
			ST_READ: begin
				cmd.sel_nxt = 1'b1;
				state_d     = ST_FUT;
			end
			ST_FUT: begin
				cmd.fut = 1'b1;
				state_d = ST_TGT;
			end
			ST_TGT: begin
				cmd.tgt = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!stat.out_busy) begin
					cmd.wr  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

### src/gqls_dp.sv
// datapath of the grid q-learning step block: tables, agent state, update arithmetic
module gqls_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gqls_pkg::dp_cmd_t                    cmd,
	output gqls_pkg::dp_stat_t                   stat,
	input  logic [gqls_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic                                 cfg_valid,
	input  logic [gqls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gqls_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [gqls_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tlast,
	output logic                                 m_tuser
);
	import gqls_pkg::*;

	localparam logic signed [36:0] Q_MAX = 37'sd2147483647;
	localparam logic signed [36:0] Q_MIN = -37'sd2147483648;

	// configuration registers
	logic [15:0]       lr_q;
	logic [15:0]       disc_q;
	logic signed [7:0] bomb_q;
	logic signed [7:0] empty_q;
	logic signed [7:0] charge_q;
	logic signed [7:0] goal_q;
	logic [EPS_W-1:0]  decay_q;

	// agent state
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic [EPS_W-1:0]  eps_q;
	logic [CELL_W-1:0] clr_cnt_q;

	// memories
	logic [NACT*QW-1:0]           qmem [CELLS];
	logic [2:0]                   tmem [CELLS];
	logic [NACT-1:0][QW-1:0]      qrow_q;
	logic [2:0]                   tile_rd_q;
	logic [CELL_W-1:0]            cur_cell;
	logic [CELL_W-1:0]            nxt_cell;
	logic [CELL_W-1:0]            raddr;

	// input fields
	logic [7:0] in_index;
	logic [2:0] in_type;
	logic [6:0] rp_q;
	logic [1:0] ra_q;

	// choose stage
	logic [NACT-1:0]         vcur;
	logic                    explore_d;
	logic [1:0]              best_d;
	logic [1:0]              exploit_a;
	logic [1:0]              explore_a;
	logic signed [QW-1:0]    bestv;
	logic                    first_c;
	logic [1:0]              rot_a;
	logic [RW-1:0]           nr_d;
	logic [CW-1:0]           nc_d;
	logic [1:0]              best_s1;
	logic                    explore_s1;
	logic [RW-1:0]           nr_s1;
	logic [CW-1:0]           nc_s1;
	logic [NACT-1:0][QW-1:0] cur_row_s1;

	// future stage
	logic [NACT-1:0]      vnxt;
	logic signed [QW-1:0] futv;
	logic                 first_f;
	logic signed [7:0]    reward_d;
	logic signed [7:0]    reward_s2;
	logic                 ended_s2;
	logic signed [48:0]   dprod_s2;

	// target, multiply and write
	logic signed [QW-1:0] q_cur;
	logic signed [48:0]   dsum;
	logic signed [34:0]   target_d;
	logic signed [34:0]   diff_s3;
	logic signed [51:0]   lprod_s4;
	logic signed [51:0]   lsum;
	logic signed [36:0]   nv_wide;
	logic signed [QW-1:0] nv;
	logic [NACT-1:0][QW-1:0] new_row;

	// output register
	logic                 m_tvalid_q;
	logic [1:0]           out_act_q;
	logic [3:0]           out_row_q;
	logic [3:0]           out_col_q;
	logic [7:0]           out_rew_q;
	logic [QW-1:0]        out_val_q;
	logic                 out_end_q;
	logic                 out_exp_q;

	assign in_index = s_tdata[7:0];
	assign in_type  = s_tdata[10:8];

	assign cur_cell = CELL_W'(row_q * COLS + col_q);
	assign nxt_cell = CELL_W'(nr_s1 * COLS + nc_s1);
	assign raddr    = cmd.sel_nxt ? nxt_cell : cur_cell;

	assign stat.clear_last = (clr_cnt_q == CELL_W'(CELLS - 1));
	assign stat.out_busy   = m_tvalid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q     <= 16'd6554;
			disc_q   <= 16'd64881;
			bomb_q   <= -8'sd100;
			empty_q  <= -8'sd1;
			charge_q <= 8'sd1;
			goal_q   <= 8'sd100;
			decay_q  <= EPS_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LEARNING_RATE: lr_q     <= cfg_data;
				CFG_DISCOUNT:      disc_q   <= cfg_data;
				CFG_BOMB_REWARD:   bomb_q   <= cfg_data[7:0];
				CFG_EMPTY_REWARD:  empty_q  <= cfg_data[7:0];
				CFG_CHARGE_REWARD: charge_q <= cfg_data[7:0];
				CFG_END_REWARD:    goal_q   <= cfg_data[7:0];
				CFG_EPSILON_DECAY: decay_q  <= cfg_data[EPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + CELL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			qmem[clr_cnt_q] <= '0;
		end else if (cmd.wr) begin
			qmem[cur_cell] <= new_row;
		end
		qrow_q <= qmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			tmem[clr_cnt_q] <= TILE_EMPTY;
		end else if (cmd.load && (int'(in_index) < CELLS)) begin
			tmem[CELL_W'(in_index)] <= in_type;
		end
		tile_rd_q <= tmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rp_q <= s_tdata[17:11];
			ra_q <= s_tdata[19:18];
		end
	end

	// action choice on the current cell
	always_comb begin
		vcur[ACT_UP]    = (row_q != '0);
		vcur[ACT_RIGHT] = (col_q != CW'(COLS - 1));
		vcur[ACT_DOWN]  = (row_q != RW'(ROWS - 1));
		vcur[ACT_LEFT]  = (col_q != '0);
		explore_d = !((11'(rp_q) * 11'd10) <= (11'(EPS_FULL) - 11'(eps_q)));
		exploit_a = ACT_UP;
		bestv     = '0;
		first_c   = 1'b1;
		for (int a = 0; a < NACT; a++) begin
			if (vcur[a] && (first_c || ($signed(qrow_q[a]) > bestv))) begin
				bestv     = $signed(qrow_q[a]);
				exploit_a = 2'(a);
				first_c   = 1'b0;
			end
		end
		explore_a = ra_q;
		for (int k = NACT - 1; k >= 0; k--) begin
			rot_a = ra_q + 2'(k);
			if (vcur[rot_a]) begin
				explore_a = rot_a;
			end
		end
		rot_a  = explore_a;
		best_d = explore_d ? explore_a : exploit_a;
		nr_d   = row_q;
		nc_d   = col_q;
		case (best_d)
			ACT_UP:    nr_d = row_q - RW'(1);
			ACT_RIGHT: nc_d = col_q + CW'(1);
			ACT_DOWN:  nr_d = row_q + RW'(1);
			ACT_LEFT:  nc_d = col_q - CW'(1);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.choose) begin
			best_s1    <= best_d;
			explore_s1 <= explore_d;
			nr_s1      <= nr_d;
			nc_s1      <= nc_d;
			cur_row_s1 <= qrow_q;
		end
	end

	// reward and best value of the entered cell
	always_comb begin
		vnxt[ACT_UP]    = (nr_s1 != '0);
		vnxt[ACT_RIGHT] = (nc_s1 != CW'(COLS - 1));
		vnxt[ACT_DOWN]  = (nr_s1 != RW'(ROWS - 1));
		vnxt[ACT_LEFT]  = (nc_s1 != '0);
		futv    = '0;
		first_f = 1'b1;
		for (int a = 0; a < NACT; a++) begin
			if (vnxt[a] && (first_f || ($signed(qrow_q[a]) > futv))) begin
				futv    = $signed(qrow_q[a]);
				first_f = 1'b0;
			end
		end
		case (tile_rd_q)
			TILE_EMPTY:  reward_d = empty_q;
			TILE_BOMB:   reward_d = bomb_q;
			TILE_CHARGE: reward_d = charge_q;
			TILE_GOAL:   reward_d = goal_q;
			default:     reward_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.fut) begin
			reward_s2 <= reward_d;
			ended_s2  <= (tile_rd_q == TILE_BOMB) || (tile_rd_q == TILE_GOAL);
			dprod_s2  <= $signed({1'b0, disc_q}) * futv;
		end
	end

	assign q_cur    = $signed(cur_row_s1[best_s1]);
	assign dsum     = dprod_s2 + 49'sd32768;
	assign target_d = $signed({{11{reward_s2[7]}}, reward_s2, 16'h0000})
		+ $signed({{2{dsum[48]}}, dsum[48:16]});

	always_ff @(posedge clk) begin
		if (cmd.tgt) begin
			diff_s3 <= target_d - $signed({{3{q_cur[QW-1]}}, q_cur});
		end
		if (cmd.mul) begin
			lprod_s4 <= $signed({1'b0, lr_q}) * diff_s3;
		end
	end

	assign lsum    = lprod_s4 + 52'sd32768;
	assign nv_wide = $signed({lsum[51], lsum[51:16]})
		+ $signed({{5{q_cur[QW-1]}}, q_cur});

	always_comb begin
		if (nv_wide > Q_MAX) begin
			nv = Q_MAX[QW-1:0];
		end else if (nv_wide < Q_MIN) begin
			nv = Q_MIN[QW-1:0];
		end else begin
			nv = nv_wide[QW-1:0];
		end
		new_row          = cur_row_s1;
		new_row[best_s1] = nv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			eps_q <= EPS_FULL;
		end else if (cmd.wr) begin
			if (ended_s2) begin
				row_q <= '0;
				col_q <= '0;
				eps_q <= (eps_q >= decay_q) ? eps_q - decay_q : '0;
			end else begin
				row_q <= nr_s1;
				col_q <= nc_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.wr) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			out_act_q <= best_s1;
			out_row_q <= 4'(nr_s1);
			out_col_q <= 4'(nc_s1);
			out_rew_q <= reward_s2;
			out_val_q <= nv;
			out_end_q <= ended_s2;
			out_exp_q <= explore_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'h00, out_val_q, out_rew_q, out_col_q, out_row_q, out_act_q};
	assign m_tlast  = out_end_q;
	assign m_tuser  = out_exp_q;

`ifndef NO_ASSERTIONS
	a_eps_never_rises: assert property (@(posedge clk) disable iff (!arst_n)
		eps_q <= $past(eps_q))
		else $error("epsilon increased");

	a_result_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(cmd.wr))
		else $error("result shown without a write");

	a_episode_home: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr && ended_s2) |=> (row_q == '0) && (col_q == '0))
		else $error("agent not back at origin after episode end");
`endif

endmodule

### test/testbench.sv
// self-checking testbench of the grid q-learning step block
module testbench;
	import gqls_pkg::*;

	localparam int HALF_HI    = 6;
	localparam int HALF_LO    = 6;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_WAIT = 24;

	typedef struct {
		logic       op;
		logic [7:0] index;
		logic [2:0] kind;
		logic [6:0] pct;
		logic [1:0] rand_act;
	} grid_item_t;

	typedef struct {
		logic [1:0]         act;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [7:0]  reward;
		logic signed [31:0] value;
		logic               ended;
		logic               explored;
	} step_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	grid_item_t pending_items[$];
	step_result_t due_steps[$];
	grid_item_t held_item;
	int errors = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit tx_hold = 0;
	int rx_hold_requests = 0;
	int rx_hold_served = 0;
	int rx_hold_left = 0;
	int quiet_cycles = 0;

	// predictor state
	logic signed [31:0] qtab[CELLS*NACT];
	logic [2:0] maze[CELLS];
	int agent_r = 0;
	int agent_c = 0;
	int eps = 1000;
	longint lr = 6554;
	longint disc = 64881;
	int rw_bomb = -100;
	int rw_empty = -1;
	int rw_charge = 1;
	int rw_end = 100;
	int eps_decay = 1;

	int dr[4] = '{-1, 0, 1, 0};
	int dc[4] = '{0, 1, 0, -1};

	grid_q_learning_step_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#HALF_HI clk = 1'b0;
		#HALF_LO clk = 1'b1;
	end

	function automatic bit on_grid(int r, int c);
		return r >= 0 && r < ROWS && c >= 0 && c < COLS;
	endfunction

	function automatic longint frac_round(longint frac, longint v);
		return (frac * v + 64'sd32768) >>> 16;
	endfunction

	task automatic advance_agent(grid_item_t it);
		int cur, nxt, nr, nc, best, rew, a, k;
		bit expl, first, ended;
		logic signed [31:0] bestv, futv;
		longint qv, target, nv;
		step_result_t res;
		bestv = 0;
		futv = 0;
		best = 0;
		cur = agent_r * COLS + agent_c;
		expl = !(int'(it.pct) * 10 <= 1000 - eps);
		if (!expl) begin
			first = 1;
			for (a = 0; a < NACT; a++) begin
				if (on_grid(agent_r + dr[a], agent_c + dc[a]) &&
				    (first || qtab[cur*NACT+a] > bestv)) begin
					bestv = qtab[cur*NACT+a];
					best = a;
					first = 0;
				end
			end
		end else begin
			best = it.rand_act;
			for (k = 0; k < NACT; k++) begin
				a = (int'(it.rand_act) + k) % NACT;
				if (on_grid(agent_r + dr[a], agent_c + dc[a])) begin
					best = a;
					break;
				end
			end
		end
		nr = agent_r + dr[best];
		nc = agent_c + dc[best];
		nxt = nr * COLS + nc;
		case (maze[nxt])
			TILE_EMPTY: rew = rw_empty;
			TILE_BOMB: rew = rw_bomb;
			TILE_CHARGE: rew = rw_charge;
			TILE_GOAL: rew = rw_end;
			default: rew = 0;
		endcase
		first = 1;
		for (a = 0; a < NACT; a++) begin
			if (on_grid(nr + dr[a], nc + dc[a]) && (first || qtab[nxt*NACT+a] > futv)) begin
				futv = qtab[nxt*NACT+a];
				first = 0;
			end
		end
		qv = qtab[cur*NACT+best];
		target = longint'(rew) * 65536 + frac_round(disc, longint'(futv));
		nv = qv + frac_round(lr, target - qv);
		if (nv > 64'sd2147483647) nv = 64'sd2147483647;
		if (nv < -64'sd2147483648) nv = -64'sd2147483648;
		qtab[cur*NACT+best] = 32'(nv);
		ended = maze[nxt] == TILE_BOMB || maze[nxt] == TILE_GOAL;
		if (ended) begin
			agent_r = 0;
			agent_c = 0;
			eps = eps >= eps_decay ? eps - eps_decay : 0;
		end else begin
			agent_r = nr;
			agent_c = nc;
		end
		res.act = 2'(best);
		res.row = 4'(nr);
		res.col = 4'(nc);
		res.reward = 8'(rew);
		res.value = 32'(nv);
		res.ended = ended;
		res.explored = expl;
		due_steps.push_back(res);
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		grid_item_t nxt_item;
		bit offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (held_item.op == OP_STEP)
					advance_agent(held_item);
				else if (held_item.index < CELLS)
					maze[held_item.index] = held_item.kind;
			end
			if (!s_tvalid || s_tready) begin
				offer = pending_items.size() != 0 && !tx_hold &&
				        $urandom_range(99) >= tx_idle_pct;
				if (offer) begin
					nxt_item = pending_items.pop_front();
					held_item = nxt_item;
					s_tdata <= {4'b0, nxt_item.rand_act, nxt_item.pct, nxt_item.kind,
					            nxt_item.index};
					s_tuser <= nxt_item.op;
				end
				s_tvalid <= offer;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		step_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_steps.size() == 0) begin
					report("unexpected transfer", 0, 0);
				end else begin
					want = due_steps.pop_front();
					if (m_tdata[1:0] !== want.act) report("action", m_tdata[1:0], want.act);
					if (m_tdata[5:2] !== want.row) report("row", m_tdata[5:2], want.row);
					if (m_tdata[9:6] !== want.col) report("col", m_tdata[9:6], want.col);
					if (m_tdata[17:10] !== want.reward)
						report("reward", $signed(m_tdata[17:10]), want.reward);
					if (m_tdata[49:18] !== want.value)
						report("value", $signed(m_tdata[49:18]), want.value);
					if (m_tlast !== want.ended) report("episode end", m_tlast, want.ended);
					if (m_tuser !== want.explored) report("explored", m_tuser, want.explored);
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left <= rx_hold_left - 1;
				m_tready <= 1'b0;
			end else if (rx_hold_served != rx_hold_requests) begin
				rx_hold_served <= rx_hold_requests;
				rx_hold_left <= 400;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(99) >= rx_stall_pct;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LEARNING_RATE: lr = val;
			CFG_DISCOUNT: disc = val;
			CFG_BOMB_REWARD: rw_bomb = $signed(val[7:0]);
			CFG_EMPTY_REWARD: rw_empty = $signed(val[7:0]);
			CFG_CHARGE_REWARD: rw_charge = $signed(val[7:0]);
			CFG_END_REWARD: rw_end = $signed(val[7:0]);
			CFG_EPSILON_DECAY: eps_decay = val[9:0];
			default: ;
		endcase
	endtask

	task automatic cfg_all(int l, int d, int b, int e, int c, int g, int dec);
		cfg_write(CFG_LEARNING_RATE, 16'(l));
		cfg_write(CFG_DISCOUNT, 16'(d));
		cfg_write(CFG_BOMB_REWARD, 16'(b & 8'hff));
		cfg_write(CFG_EMPTY_REWARD, 16'(e & 8'hff));
		cfg_write(CFG_CHARGE_REWARD, 16'(c & 8'hff));
		cfg_write(CFG_END_REWARD, 16'(g & 8'hff));
		cfg_write(CFG_EPSILON_DECAY, 16'(dec));
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending_items.size() != 0 || s_tvalid || due_steps.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic push_item(logic op, int index, int kind, int pct, int act);
		grid_item_t it;
		it.op = op;
		it.index = 8'(index);
		it.kind = 3'(kind);
		it.pct = 7'(pct);
		it.rand_act = 2'(act);
		pending_items.push_back(it);
	endtask

	task automatic push_random(int n);
		int pct;
		repeat (n) begin
			if ($urandom_range(99) < 15) begin
				push_item(OP_LOAD, $urandom_range(255), $urandom_range(7),
				          $urandom_range(127), $urandom_range(3));
			end else begin
				pct = $urandom_range(99) < 85 ? $urandom_range(1, 100) : $urandom_range(127);
				push_item(OP_STEP, $urandom_range(255), $urandom_range(7), pct,
				          $urandom_range(3));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < CELLS*NACT; i++) qtab[i] = 0;
		for (int i = 0; i < CELLS; i++) maze[i] = TILE_EMPTY;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		cfg_all(6554, 64881, -100, -1, 1, 100, 1);
		// corner moves, every tile kind, draw extremes
		push_item(OP_LOAD, 1, TILE_CHARGE, 127, 3);
		push_item(OP_LOAD, 2, TILE_START, 0, 0);
		push_item(OP_LOAD, 3, 7, 0, 0);
		push_item(OP_LOAD, 4, 5, 0, 0);
		push_item(OP_LOAD, 16, TILE_BOMB, 0, 0);
		push_item(OP_LOAD, 255, TILE_GOAL, 0, 0);
		push_item(OP_LOAD, 18, TILE_GOAL, 0, 0);
		push_item(OP_STEP, 255, 7, 0, 0);
		push_item(OP_STEP, 0, 0, 127, ACT_UP);
		push_item(OP_STEP, 0, 0, 1, ACT_RIGHT);
		push_item(OP_STEP, 0, 0, 100, ACT_RIGHT);
		push_item(OP_STEP, 0, 0, 100, ACT_LEFT);
		push_item(OP_STEP, 0, 0, 50, ACT_DOWN);
		push_item(OP_STEP, 0, 0, 50, ACT_LEFT);
		push_item(OP_STEP, 0, 0, 0, ACT_UP);
		push_item(OP_STEP, 0, 0, 99, ACT_DOWN);
		push_item(OP_STEP, 0, 0, 0, ACT_LEFT);
		push_item(OP_STEP, 0, 0, 127, ACT_UP);
		push_item(OP_LOAD, 0, TILE_EMPTY, 0, 0);
		push_item(OP_STEP, 0, 0, 2, ACT_UP);
		push_random(120);
		wait_drained();

		tx_idle_pct = 78;
		cfg_all(65535, 0, -128, 127, 0, -1, 1000);
		push_random(160);
		wait_drained();

		tx_idle_pct = 0;
		rx_stall_pct = 78;
		cfg_all(0, 65535, 127, -128, -128, 127, 0);
		push_random(160);
		wait_drained();

		tx_idle_pct = 11;
		rx_stall_pct = 11;
		cfg_all($urandom_range(65535), $urandom_range(65535), $urandom_range(255) - 128,
		        $urandom_range(255) - 128, $urandom_range(255) - 128,
		        $urandom_range(255) - 128, $urandom_range(40));
		push_random(160);
		wait_drained();

		// long receiver hold while items keep coming, then a full pause of the sender
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		cfg_all(32768, 65535, -100, -1, 1, 100, 7);
		rx_hold_requests++;
		push_random(60);
		do @(posedge clk); while (pending_items.size() > 30);
		tx_hold = 1;
		do @(posedge clk); while (s_tvalid || due_steps.size() != 0);
		tx_hold = 0;
		push_random(60);
		wait_drained();

		if (due_steps.size() != 0) report("results never delivered", 0, due_steps.size());
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
